// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the occupancy replacement unit.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hw/rtl/ocr_pkg.sv =====
// Package for the occupancy replacement unit: state type and constants.
// No dependencies.
package ocr_pkg;
  localparam logic [7:0] OCC_MAX     = 8'd255;
  localparam logic [3:0] PRIO_TOP    = 4'd15;
  localparam logic [3:0] PRIO_RESET  = 4'd7;
  localparam logic [7:0] LIMIT_RESET = 8'd13;
  localparam int unsigned MASK_BITS  = 8;
  localparam logic       CMD_ACCESS  = 1'b0;
  localparam logic       CMD_VICTIM  = 1'b1;
  localparam logic [1:0] OUT_NONE    = 2'd0;
  localparam logic [1:0] OUT_FRIEND  = 2'd1;
  localparam logic [1:0] OUT_AVERSE  = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_ZERO, ST_CHK_RD, ST_CHK, ST_INC_RD, ST_INC,
    ST_VICT, ST_DONE
  } state_t;
endpackage

// ===== hw/rtl/ocr_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module ocr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/optgen_occupancy_replacement_unit.sv =====
// Occupancy replacement unit: OPTgen occupancy history in a RAM plus per-way priorities.
// Depends on ocr_pkg, ocr_ram and assert_macros.svh.
// Operation: a victim request takes an invalid way or scans up to 16 priority levels;
// an access zeroes the current slot, then makes a check pass over the interval and,
// if no slot is at the limit, an increment pass. One item at a time; the RAM port
// sets the rate. Reset: synchronous; a clearing pass zeroes every RAM entry first.
`include "assert_macros.svh"
module optgen_occupancy_replacement_unit import ocr_pkg::*; #(
  parameter int WAYS          = 8,
  parameter int HISTORY_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       command,
  input  logic [2:0] way,
  input  logic [7:0] valid_mask,
  input  logic [7:0] evictable_mask,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] victim_way,
  output logic       victim_found,
  output logic [1:0] access_outcome,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);
  localparam int HW = $clog2(HISTORY_DEPTH);
  localparam int WW = $clog2(WAYS);

  state_t state, state_next;
  logic [7:0]    limit;
  logic [HW-1:0] ptr, idx, clr;
  logic [HW-1:0] last_slot [WAYS];
  logic [WAYS-1:0] slot_valid;
  logic [3:0]    prio [WAYS];
  logic          cmd_r;
  logic [3:0]    wq;
  logic [7:0]    vm, em;
  logic [3:0]    target;

  logic          we;
  logic [HW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  ocr_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_occ (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  logic [WW-1:0] wsel;
  assign wsel = wq[WW-1:0];
  logic way_ok;
  assign way_ok = ({28'd0, wq} < 32'(WAYS));
  logic [HW-1:0] idx_inc;
  assign idx_inc = (32'(idx) + 1 >= HISTORY_DEPTH) ? '0 : idx + 1'b1;

  // Victim scan helpers: lowest invalid way, and lowest evictable way at the current level.
  logic          inv_hit, lvl_hit;
  logic [WW-1:0] inv_way, lvl_way;
  always_comb begin
    inv_hit = 1'b0; inv_way = '0; lvl_hit = 1'b0; lvl_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (i < MASK_BITS && !vm[i % MASK_BITS]) begin
        inv_hit = 1'b1; inv_way = WW'(i);
      end
      if (i < MASK_BITS && em[i % MASK_BITS] && prio[i] == target) begin
        lvl_hit = 1'b1; lvl_way = WW'(i);
      end
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign out_valid = (state == ST_DONE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (32'(clr) == HISTORY_DEPTH - 1) state_next = ST_IDLE;
      ST_IDLE:   if (in_valid) state_next = (command == CMD_ACCESS) ? ST_ZERO : ST_VICT;
      ST_ZERO:   state_next = (!way_ok) ? ST_DONE
                            : (slot_valid[wsel] && last_slot[wsel] != ptr) ? ST_CHK_RD
                            : ST_DONE;
      ST_CHK_RD: state_next = ST_CHK;
      ST_CHK:    if (rdata >= limit) state_next = ST_DONE;
                 else if (idx_inc == ptr) state_next = ST_INC_RD;
                 else state_next = ST_CHK_RD;
      ST_INC_RD: state_next = ST_INC;
      ST_INC:    state_next = (idx_inc == ptr) ? ST_DONE : ST_INC_RD;
      ST_VICT:   if (inv_hit || lvl_hit || target == 4'd0) state_next = ST_DONE;
      ST_DONE:   if (!out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // An access to a way outside the set leaves the history untouched.
  always_comb begin
    we = 1'b0; waddr = idx; wdata = '0; raddr = idx;
    unique case (state)
      ST_CLEAR: begin we = 1'b1; waddr = clr; end
      ST_ZERO:  begin we = way_ok; waddr = ptr; end
      ST_INC:   begin we = 1'b1; wdata = (rdata < OCC_MAX) ? rdata + 8'd1 : rdata; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr <= '0; ptr <= '0; limit <= LIMIT_RESET; slot_valid <= '0;
      for (int i = 0; i < WAYS; i++) prio[i] <= PRIO_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) limit <= cfg_data;
      unique case (state)
        ST_CLEAR: clr <= clr + 1'b1;
        ST_IDLE: if (in_valid) begin
          cmd_r <= command; wq <= {1'b0, way}; vm <= valid_mask; em <= evictable_mask;
          target <= PRIO_TOP;
          victim_way <= '0; victim_found <= 1'b0; access_outcome <= OUT_NONE;
        end
        ST_ZERO: if (way_ok) begin
          for (int i = 0; i < WAYS; i++)
            if (i == int'(wsel)) slot_valid[i] <= 1'b1;
            else if (slot_valid[i] && last_slot[i] == ptr) slot_valid[i] <= 1'b0;
          idx <= last_slot[wsel];
          if (!(slot_valid[wsel] && last_slot[wsel] != ptr)) begin
            last_slot[wsel] <= ptr; prio[wsel] <= '0;
            ptr <= (32'(ptr) + 1 >= HISTORY_DEPTH) ? '0 : ptr + 1'b1;
          end
        end
        ST_CHK: if (rdata >= limit) begin
          access_outcome <= OUT_AVERSE; last_slot[wsel] <= ptr; prio[wsel] <= PRIO_TOP;
          ptr <= (32'(ptr) + 1 >= HISTORY_DEPTH) ? '0 : ptr + 1'b1;
        end else if (idx_inc == ptr) idx <= last_slot[wsel];
        else idx <= idx_inc;
        ST_INC: if (idx_inc == ptr) begin
          access_outcome <= OUT_FRIEND; last_slot[wsel] <= ptr; prio[wsel] <= '0;
          ptr <= (32'(ptr) + 1 >= HISTORY_DEPTH) ? '0 : ptr + 1'b1;
        end else idx <= idx_inc;
        ST_VICT: begin
          if (inv_hit) begin
            victim_way <= 3'(inv_way); victim_found <= 1'b1;
          end else if (lvl_hit) begin
            victim_way <= 3'(lvl_way); victim_found <= 1'b1;
            for (int i = 0; i < WAYS; i++)
              if (WW'(i) == lvl_way) prio[i] <= '0;
              else if (prio[i] < target) prio[i] <= prio[i] + 4'd1;
          end else target <= target - 4'd1;
        end
        default: ;
      endcase
    end
  end

  `ASSERT_IMPL(a_no_accept_busy, clk, rst, state != ST_IDLE, in_stall, "accept while busy")
  `ASSERT_IMPL(a_out_only_done, clk, rst, out_valid, state == ST_DONE, "result outside done")
  `ASSERT_IMPL(a_acc_found, clk, rst, out_valid && cmd_r == CMD_ACCESS, !victim_found, "bad access")
endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the occupancy replacement unit.
// Depends on ocr_pkg and optgen_occupancy_replacement_unit; predicts each result
// from its own copy of the history, last-slot and priority state.
module tb import ocr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NWAYS = 8;
  localparam int DEPTH = 64;
  localparam int MAX_CYCLES = 2000000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       command = CMD_ACCESS;
  logic [2:0] way = '0;
  logic [7:0] valid_mask = '0;
  logic [7:0] evictable_mask = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] victim_way;
  logic       victim_found;
  logic [1:0] access_outcome;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_data = '0;

  typedef struct packed {
    logic [2:0] victim_way;
    logic       victim_found;
    logic [1:0] access_outcome;
  } result_t;

  // Predictor state.
  logic [7:0] occ [DEPTH];
  logic       slot_ok [NWAYS];
  logic [5:0] slot_of [NWAYS];
  logic [3:0] prio [NWAYS];
  logic [5:0] hist_ptr;
  logic [7:0] occ_limit;

  result_t expected_q[$];
  int      errors = 0;
  int      cycles = 0;
  int      hold_off = 0;
  int      rx_wait = 0;
  bit      random_stall = 1'b1;

  optgen_occupancy_replacement_unit #(.WAYS(NWAYS), .HISTORY_DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .way(way), .valid_mask(valid_mask),
    .evictable_mask(evictable_mask), .out_valid(out_valid), .out_stall(out_stall),
    .victim_way(victim_way), .victim_found(victim_found),
    .access_outcome(access_outcome), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic result_t predict_access(input logic [2:0] w);
    result_t r;
    logic [5:0] i;
    int avail;
    int total;
    r = '0;
    for (int k = 0; k < NWAYS; k++)
      if (slot_ok[k] && slot_of[k] == hist_ptr) slot_ok[k] = 1'b0;
    occ[hist_ptr] = '0;
    if (slot_ok[w]) begin
      avail = 0;
      total = 0;
      for (i = slot_of[w]; i != hist_ptr; i++) begin
        if (occ[i] < occ_limit) avail++;
        total++;
      end
      if (avail == total && avail > 0) begin
        for (i = slot_of[w]; i != hist_ptr; i++)
          if (occ[i] != OCC_MAX) occ[i] = occ[i] + 8'd1;
        r.access_outcome = OUT_FRIEND;
      end else if (avail < total) begin
        r.access_outcome = OUT_AVERSE;
      end
    end
    slot_ok[w] = 1'b1;
    slot_of[w] = hist_ptr;
    prio[w] = (r.access_outcome == OUT_AVERSE) ? PRIO_TOP : 4'd0;
    hist_ptr++;
    return r;
  endfunction

  function automatic result_t predict_victim(input logic [7:0] vm, input logic [7:0] em);
    result_t r;
    int pick;
    r = '0;
    pick = -1;
    for (int k = 0; k < NWAYS; k++)
      if (!vm[k]) begin
        r.victim_way = k[2:0];
        r.victim_found = 1'b1;
        return r;
      end
    for (int p = 15; p >= 0 && pick < 0; p--)
      for (int k = 0; k < NWAYS; k++)
        if (pick < 0 && prio[k] == p[3:0] && em[k]) pick = k;
    if (pick >= 0) begin
      for (int k = 0; k < NWAYS; k++)
        if (prio[k] < prio[pick]) prio[k] = prio[k] + 4'd1;
      prio[pick] = '0;
      r.victim_way = pick[2:0];
      r.victim_found = 1'b1;
    end
    return r;
  endfunction

  // Valid stays high after the transfer until the next item or a gap replaces it;
  // the block is busy by then, so the old payload is never taken twice.
  task automatic send_item(input logic cmd, input logic [2:0] w,
                           input logic [7:0] vm, input logic [7:0] em);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    command <= cmd;
    way <= w;
    valid_mask <= vm;
    evictable_mask <= em;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == CMD_ACCESS) expected_q.push_back(predict_access(w));
    else expected_q.push_back(predict_victim(vm, em));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() > 0) @(negedge clk);
    // Let the block settle.
    repeat (300) @(negedge clk);
  endtask

  task automatic write_limit(input logic [7:0] value);
    drain();
    cfg_data <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    occ_limit = value;
  endtask

  // Receiver: a drawn wait per transfer while random stalls are on, or a long hold-off when requested.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else if (random_stall && out_valid && rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait <= rx_wait - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      rx_wait <= $urandom_range(0, 4);
      got = '{victim_way, victim_found, access_outcome};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.victim_way !== exp_r.victim_way) begin
          $display("%0t: victim_way expected %0d actual %0d", $time,
                   exp_r.victim_way, got.victim_way);
          errors++;
        end
        if (got.victim_found !== exp_r.victim_found) begin
          $display("%0t: victim_found expected %0d actual %0d", $time,
                   exp_r.victim_found, got.victim_found);
          errors++;
        end
        if (got.access_outcome !== exp_r.access_outcome) begin
          $display("%0t: access_outcome expected %0d actual %0d", $time,
                   exp_r.access_outcome, got.access_outcome);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_item(CMD_ACCESS, 3'd0, 8'h00, 8'h00);
    send_item(CMD_ACCESS, 3'd7, 8'hFF, 8'hFF);
    send_item(CMD_ACCESS, 3'd0, 8'h00, 8'h00);
    send_item(CMD_ACCESS, 3'd7, 8'h00, 8'h00);
    send_item(CMD_VICTIM, 3'd0, 8'h00, 8'hFF);
    send_item(CMD_VICTIM, 3'd5, 8'hDF, 8'h00);
    send_item(CMD_VICTIM, 3'd2, 8'hFF, 8'hFF);
    send_item(CMD_VICTIM, 3'd0, 8'hFF, 8'h00);
    send_item(CMD_VICTIM, 3'd0, 8'hFF, 8'h80);
    send_item(CMD_VICTIM, 3'd0, 8'h7F, 8'h80);
    for (int k = 0; k < 8; k++) send_item(CMD_ACCESS, 3'd3, 8'h00, 8'h00);
  endtask

  // Sweeps the pointer around the history, so stale slots get invalidated.
  task automatic test_wraparound();
    for (int k = 0; k < 70; k++) send_item(CMD_ACCESS, 3'd1, 8'h55, 8'hAA);
    send_item(CMD_ACCESS, 3'd0, 8'h00, 8'h00);
    for (int k = 0; k < 70; k++) send_item(CMD_ACCESS, k[2:0], 8'hFF, 8'hFF);
  endtask

  // Builds up occupancy with a large limit, drives averse outcomes at zero, then random ways at one.
  task automatic test_limits();
    write_limit(8'd255);
    for (int k = 0; k < 300; k++) send_item(CMD_ACCESS, k[0] ? 3'd2 : 3'd6, 8'hFF, 8'h00);
    write_limit(8'd0);
    for (int k = 0; k < 20; k++) send_item(CMD_ACCESS, k[2:0], 8'hFF, 8'hFF);
    write_limit(8'd1);
    for (int k = 0; k < 20; k++)
      send_item(CMD_ACCESS, 3'($urandom_range(0, 7)), 8'h00, 8'h00);
  endtask

  task automatic test_backpressure();
    hold_off <= 400;
    for (int k = 0; k < 12; k++)
      send_item(k[0], 3'($urandom_range(0, 7)), 8'hFF, 8'($urandom));
    drain();
  endtask

  task automatic test_random(input int count);
    logic [7:0] vm;
    for (int k = 0; k < count; k++) begin
      if (k % 300 == 0) write_limit(8'($urandom_range(0, 255)));
      if (k % 200 == 100) random_stall = !random_stall;
      vm = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hFF;
      send_item($urandom_range(0, 2) == 0, 3'($urandom_range(0, 7)), vm, 8'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    occ_limit = LIMIT_RESET;
    hist_ptr = '0;
    for (int k = 0; k < DEPTH; k++) occ[k] = '0;
    for (int k = 0; k < NWAYS; k++) begin
      slot_ok[k] = 1'b0;
      slot_of[k] = '0;
      prio[k] = PRIO_RESET;
    end
    test_directed();
    test_wraparound();
    test_limits();
    test_backpressure();
    test_random(780);
    write_limit(LIMIT_RESET);
    drain();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ocr_pkg.sv
hw/rtl/ocr_ram.sv
hw/rtl/optgen_occupancy_replacement_unit.sv
verif/tb.sv
